/* sv/msc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes for the single-cycle MIPS subset core.
package msc_pkg;

   localparam int DMEM_WORDS = 128;
   localparam int DMEM_AW    = $clog2(DMEM_WORDS);
   localparam int REG_COUNT  = 32;
   localparam int REG_AW     = $clog2(REG_COUNT);

   localparam logic [31:0] DMEM_WORDS_U = 32'(DMEM_WORDS);
   localparam logic [32:0] DMEM_BYTES   = 33'(DMEM_WORDS * 4);

   localparam logic [31:0] PC_RESET        = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE_RESET = 32'd268500992;

   localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(31);

   // item kinds
   localparam logic [1:0] KIND_EXEC = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_REG  = 2'd2;

   // fault codes
   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_OPCODE = 2'd1;
   localparam logic [1:0] FAULT_ADDR   = 2'd2;

   // opcodes
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_JAL   = 6'b000011;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_BNE   = 6'b000101;
   localparam logic [5:0] OP_ADDI  = 6'b001000;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   // R-type function codes
   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_JR  = 6'b001000;
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_SLT = 6'b101010;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        instruction;
      logic [DMEM_AW-1:0] word_index;
      logic [REG_AW-1:0]  reg_index;
      logic signed [31:0] preload_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0]        next_pc;
      logic               reg_written;
      logic [REG_AW-1:0]  reg_dest;
      logic signed [31:0] reg_value;
      logic               mem_written;
      logic [DMEM_AW-1:0] mem_word;
      logic signed [31:0] mem_value;
      logic [1:0]         fault;
   } rsp_item_type;

   // decoded and executed item, before the load data is known
   typedef struct packed {
      logic [31:0]        next_pc;
      logic               commit_pc;
      logic               reg_we;
      logic [REG_AW-1:0]  reg_dest;
      logic [31:0]        reg_value;
      logic               is_load;
      logic               mem_we;
      logic [DMEM_AW-1:0] mem_word;
      logic [31:0]        mem_value;
      logic [1:0]         fault;
   } exec_type;

   typedef struct packed {
      logic              we;
      logic [REG_AW-1:0] addr;
      logic [31:0]       data;
   } rf_write_type;

   typedef struct packed {
      logic               we;
      logic [DMEM_AW-1:0] addr;
      logic [31:0]        data;
   } dm_access_type;

endpackage

/* sv/msc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
interface msc_req_if import msc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface msc_rsp_if import msc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/msc_regfile.sv */
`timescale 1ns / 1ps
// Register file: two registered read ports with write bypass, plus a link register copy.
module msc_regfile import msc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr_a,
   input  logic [REG_AW-1:0] rd_addr_b,
   input  rf_write_type      wr,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b,
   output logic [31:0]       link_data
);

   logic [31:0]          mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [31:0]          rd_a_ff;
   logic [31:0]          rd_b_ff;
   logic [31:0]          link_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.we && wr.addr == rd_addr_a) begin
            rd_a_ff <= wr.data;
         end else if (valid_ff[rd_addr_a]) begin
            rd_a_ff <= mem_ff[rd_addr_a];
         end else begin
            rd_a_ff <= '0;
         end
         if (wr.we && wr.addr == rd_addr_b) begin
            rd_b_ff <= wr.data;
         end else if (valid_ff[rd_addr_b]) begin
            rd_b_ff <= mem_ff[rd_addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else if (wr.we && wr.addr == LINK_REG) begin
         link_ff <= wr.data;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
   assign link_data = link_ff;

endmodule

/* sv/msc_dmem.sv */
`timescale 1ns / 1ps
// Data memory: one access port, registered read data, per-word valid bits.
module msc_dmem import msc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  dm_access_type acc,
   output logic [31:0]   rd_data
);

   logic [31:0]           mem_ff [DMEM_WORDS];
   logic [DMEM_WORDS-1:0] valid_ff;
   logic [31:0]           rd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (acc.we) begin
            mem_ff[acc.addr] <= acc.data;
         end
         if (valid_ff[acc.addr]) begin
            rd_ff <= mem_ff[acc.addr];
         end else begin
            rd_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en && acc.we) begin
         valid_ff[acc.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_ff;

endmodule

/* sv/msc_execute.sv */
`timescale 1ns / 1ps
// Decode, ALU, branch and address logic for one word.
module msc_execute import msc_pkg::*; (
   input  req_item_type item,
   input  logic [31:0]  op_a,
   input  logic [31:0]  op_b,
   input  logic [31:0]  link,
   input  logic [31:0]  pc,
   input  logic [31:0]  data_base,
   output exec_type     exec
);

   logic [5:0]         opcode;
   logic [5:0]         funct;
   logic [REG_AW-1:0]  rt;
   logic [REG_AW-1:0]  rd;
   logic [4:0]         shamt;
   logic [31:0]        sext;
   logic [31:0]        pc4;
   logic [31:0]        sum;
   logic [31:0]        diff;
   logic [31:0]        offset;
   logic               addr_ok;
   logic [DMEM_AW-1:0] addr_word;
   logic               word_ok;
   logic [31:0]        npc;
   logic [31:0]        res;
   logic [REG_AW-1:0]  dest;
   logic               wr;
   logic               bad_op;
   logic               is_load;
   logic               is_store;

   assign opcode    = item.instruction[31:26];
   assign funct     = item.instruction[5:0];
   assign rt        = item.instruction[20:16];
   assign rd        = item.instruction[15:11];
   assign shamt     = item.instruction[10:6];
   assign sext      = {{16{item.instruction[15]}}, item.instruction[15:0]};
   assign pc4       = pc + 32'd4;
   assign sum       = op_a + sext;
   assign diff      = op_a - op_b;
   assign offset    = sum - data_base;
   assign addr_ok   = {1'b0, offset} < DMEM_BYTES;
   assign addr_word = offset[DMEM_AW+1:2];
   assign word_ok   = {{(32-DMEM_AW){1'b0}}, item.word_index} < DMEM_WORDS_U;

   // instruction decode
   always_comb begin
      npc      = pc4;
      res      = '0;
      dest     = '0;
      wr       = 1'b0;
      bad_op   = 1'b0;
      is_load  = 1'b0;
      is_store = 1'b0;
      case (opcode)
         OP_RTYPE: begin
            case (funct)
               FN_ADD: begin
                  res  = op_a + op_b;
                  dest = rd;
                  wr   = 1'b1;
               end
               FN_SUB: begin
                  res  = diff;
                  dest = rd;
                  wr   = 1'b1;
               end
               FN_SLT: begin
                  res  = {31'd0, $signed(op_a) < $signed(op_b)};
                  dest = rd;
                  wr   = 1'b1;
               end
               FN_SLL: begin
                  res  = op_b << shamt;
                  dest = rd;
                  wr   = 1'b1;
               end
               FN_JR: begin
                  npc = link;
               end
               default: begin
                  bad_op = 1'b1;
               end
            endcase
         end
         OP_ADDI: begin
            res  = sum;
            dest = rt;
            wr   = 1'b1;
         end
         OP_LW: begin
            res     = sum;
            is_load = 1'b1;
         end
         OP_SW: begin
            res      = sum;
            is_store = 1'b1;
         end
         OP_BEQ, OP_BNE: begin
            res = diff;
            if ((opcode == OP_BEQ) == (diff == '0)) begin
               npc = pc4 + {sext[29:0], 2'b00};
            end
         end
         OP_J: begin
            npc = {pc4[31:28], item.instruction[25:0], 2'b00};
         end
         OP_JAL: begin
            npc  = {pc4[31:28], item.instruction[25:0], 2'b00};
            res  = pc4;
            dest = LINK_REG;
            wr   = 1'b1;
         end
         default: begin
            bad_op = 1'b1;
         end
      endcase
   end

   always_comb begin
      exec         = '0;
      exec.next_pc = pc;
      exec.fault   = FAULT_NONE;
      case (item.kind)
         KIND_DATA: begin
            if (word_ok) begin
               exec.mem_we    = 1'b1;
               exec.mem_word  = item.word_index;
               exec.mem_value = item.preload_value;
            end else begin
               exec.fault = FAULT_ADDR;
            end
         end
         KIND_REG: begin
            exec.reg_value = item.preload_value;
            if (item.reg_index != '0) begin
               exec.reg_we   = 1'b1;
               exec.reg_dest = item.reg_index;
            end
         end
         KIND_EXEC: begin
            if (bad_op) begin
               exec.fault = FAULT_OPCODE;
            end else if ((is_load || is_store) && !addr_ok) begin
               exec.fault = FAULT_ADDR;
            end else begin
               exec.commit_pc = 1'b1;
               exec.next_pc   = npc;
               exec.reg_value = res;
               if (is_load) begin
                  exec.is_load  = 1'b1;
                  exec.mem_word = addr_word;
                  if (rt != '0) begin
                     exec.reg_we   = 1'b1;
                     exec.reg_dest = rt;
                  end
               end else if (is_store) begin
                  exec.mem_we    = 1'b1;
                  exec.mem_word  = addr_word;
                  exec.mem_value = op_b;
               end else if (wr && dest != '0) begin
                  exec.reg_we   = 1'b1;
                  exec.reg_dest = dest;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* sv/mips_single_cycle_core.sv */
`timescale 1ns / 1ps
// Top level of the MIPS32 subset core: three-stage word pipeline with output register.
//
// Each request word is one instruction (add, sub, slt, sll, jr, lw, sw, beq,
// bne, addi, j, jal) or a preload of a data word or a register; each yields
// exactly one response word with the next PC, the register write, the memory
// access and a fault code. One word is accepted every clock while the
// response side keeps up. Each word then moves through the stages in order:
// the register file read is registered on acceptance, the execute stage
// computes the result and the data address and clocks the data memory
// access, and the last stage merges load data and writes the register file
// while loading the output register, which presents the response word.
// With the response side stalled the core holds three words, one per stage,
// and then drops ready. Results of older words are forwarded to the execute
// stage, so back-to-back dependent instructions see current values. Faulting
// words (unknown opcode or funct, data address outside the 128-word memory)
// leave all state unchanged. The data_base register (csr_we / csr_wdata) maps
// a byte address onto data word zero; write it only while no word is in
// flight. After reset the register file and data memory read as zero and the
// PC is 0x00400000.
module mips_single_cycle_core import msc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   msc_req_if.sink      req_if,
   msc_rsp_if.source    rsp_if,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   // handshake and stage control
   logic         out_free;
   logic         c_adv;
   logic         c_free;
   logic         b_adv;
   logic         b_free;
   logic         accept;

   logic         b_valid_ff;
   logic         b_valid_in;
   logic         c_valid_ff;
   logic         c_valid_in;
   logic         out_valid_ff;
   logic         out_valid_in;

   req_item_type b_item_ff;
   exec_type     c_ff;
   rsp_item_type out_ff;
   rsp_item_type out_in;

   logic [31:0]  pc_ff;
   logic [31:0]  data_base_ff;

   logic [31:0]  rf_a;
   logic [31:0]  rf_b;
   logic [31:0]  rf_link;
   rf_write_type rf_wr;

   logic [REG_AW-1:0] b_rs;
   logic [REG_AW-1:0] b_rt;
   logic [31:0]  op_a;
   logic [31:0]  op_b;
   logic [31:0]  link;
   logic [31:0]  c_wb_value;
   logic         c_fwd;

   exec_type      exec;
   dm_access_type dm_acc;
   logic [31:0]   dm_rdata;

   // each stage moves when the one ahead is empty or moving
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign c_adv    = c_valid_ff && out_free;
   assign c_free   = !c_valid_ff || out_free;
   assign b_adv    = b_valid_ff && c_free;
   assign b_free   = !b_valid_ff || c_free;
   assign accept   = req_if.valid && b_free;

   assign req_if.ready = b_free;

   assign b_valid_in   = b_free ? req_if.valid : 1'b1;
   assign c_valid_in   = c_free ? b_valid_ff : 1'b1;
   assign out_valid_in = out_free ? c_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= DATA_BASE_RESET;
      end else if (csr_we) begin
         data_base_ff <= csr_wdata;
      end
   end

   // stage B: hold the accepted word while the operands are read
   always_ff @(posedge clock) begin
      if (accept) begin
         b_item_ff <= req_if.payload;
      end
   end

   // write back on the way out of stage C; reads on acceptance bypass it
   assign c_wb_value = (c_ff.is_load && c_ff.reg_we) ? dm_rdata : c_ff.reg_value;

   assign rf_wr.we   = c_adv && c_ff.reg_we;
   assign rf_wr.addr = c_ff.reg_dest;
   assign rf_wr.data = c_wb_value;

   msc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_if.payload.instruction[25:21]),
      .rd_addr_b (req_if.payload.instruction[20:16]),
      .wr        (rf_wr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .link_data (rf_link)
   );

   // forward the result of the word still in stage C
   assign b_rs  = b_item_ff.instruction[25:21];
   assign b_rt  = b_item_ff.instruction[20:16];
   assign c_fwd = c_valid_ff && c_ff.reg_we;
   assign op_a  = (c_fwd && c_ff.reg_dest == b_rs) ? c_wb_value : rf_a;
   assign op_b  = (c_fwd && c_ff.reg_dest == b_rt) ? c_wb_value : rf_b;
   assign link  = (c_fwd && c_ff.reg_dest == LINK_REG) ? c_wb_value : rf_link;

   msc_execute u_execute (
      .item      (b_item_ff),
      .op_a      (op_a),
      .op_b      (op_b),
      .link      (link),
      .pc        (pc_ff),
      .data_base (data_base_ff),
      .exec      (exec)
   );

   // advance the PC in word order; faults and preloads keep it
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
      end else if (b_adv && exec.commit_pc) begin
         pc_ff <= exec.next_pc;
      end
   end

   // stores and preloads write, loads read, as the word leaves stage B
   assign dm_acc.we   = exec.mem_we;
   assign dm_acc.addr = exec.mem_word;
   assign dm_acc.data = exec.mem_value;

   msc_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .en      (b_adv),
      .acc     (dm_acc),
      .rd_data (dm_rdata)
   );

   // stage C
   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_ff <= exec;
      end
   end

   // merge load data into the response word
   always_comb begin
      out_in.next_pc     = c_ff.next_pc;
      out_in.reg_written = c_ff.reg_we;
      out_in.reg_dest    = c_ff.reg_dest;
      out_in.reg_value   = c_wb_value;
      out_in.mem_written = c_ff.mem_we;
      out_in.mem_word    = c_ff.mem_word;
      out_in.mem_value   = c_ff.is_load ? dm_rdata : c_ff.mem_value;
      out_in.fault       = c_ff.fault;
   end

   always_ff @(posedge clock) begin
      if (c_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

   // the PC moves only with a committing word
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !(b_adv && exec.commit_pc) |=> $stable(pc_ff))
      else $error("PC changed without a committing word");

   // a faulting word changes no state
   a_fault_no_state: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && exec.fault != FAULT_NONE) |->
         (!exec.mem_we && !exec.reg_we && !exec.commit_pc))
      else $error("faulting word would change state");

   // a stalled stage C keeps its word
   a_c_hold: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !out_free) |=> (c_valid_ff && $stable(c_ff)))
      else $error("stage C lost or changed a stalled word");

   // faulted responses report no writes
   a_rsp_fault: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.fault != FAULT_NONE) |->
         (!out_ff.reg_written && !out_ff.mem_written))
      else $error("faulted response reports a write");

endmodule

/* tb/core_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the MIPS subset core: predicts each response word and compares it.
module core_result_checker import msc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   msc_req_if          req_mon,
   msc_rsp_if          rsp_mon,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          pending
);

   logic [31:0]  prog_counter;
   logic [31:0]  data_base;
   logic [31:0]  gpr [REG_COUNT];
   logic [31:0]  dmem [DMEM_WORDS];
   rsp_item_type retired_q [$];

   // Retire one request word against the local copy of the core state.
   function automatic rsp_item_type retire(input req_item_type w);
      rsp_item_type       r;
      logic [5:0]         op, fn;
      logic [4:0]         rs, rt, rd, sh, dest;
      logic [31:0]        ins, a, b, sext, pc4, npc, res, off;
      logic [DMEM_AW-1:0] wi;
      logic [1:0]         flt;
      logic               wr;
      r = '0;
      r.next_pc = prog_counter;
      case (w.kind)
         KIND_DATA: begin
            if (32'(w.word_index) >= DMEM_WORDS_U) begin
               r.fault = FAULT_ADDR;
            end else begin
               dmem[w.word_index] = w.preload_value;
               r.mem_written = 1'b1;
               r.mem_word    = w.word_index;
               r.mem_value   = w.preload_value;
            end
         end
         KIND_REG: begin
            r.reg_value = w.preload_value;
            if (w.reg_index != '0) begin
               gpr[w.reg_index] = w.preload_value;
               r.reg_written = 1'b1;
               r.reg_dest    = w.reg_index;
            end
         end
         KIND_EXEC: begin
            ins  = w.instruction;
            op   = ins[31:26];
            rs   = ins[25:21];
            rt   = ins[20:16];
            rd   = ins[15:11];
            sh   = ins[10:6];
            fn   = ins[5:0];
            sext = {{16{ins[15]}}, ins[15:0]};
            a    = gpr[rs];
            b    = gpr[rt];
            pc4  = prog_counter + 32'd4;
            npc  = pc4;
            res  = '0;
            dest = '0;
            wr   = 1'b0;
            flt  = FAULT_NONE;
            wi   = '0;
            case (op)
               OP_RTYPE: begin
                  wr   = 1'b1;
                  dest = rd;
                  case (fn)
                     FN_ADD: res = a + b;
                     FN_SUB: res = a - b;
                     FN_SLT: res = {31'b0, ($signed(a) < $signed(b))};
                     FN_SLL: res = b << sh;
                     FN_JR: begin
                        wr  = 1'b0;
                        npc = gpr[LINK_REG];
                     end
                     default: flt = FAULT_OPCODE;
                  endcase
               end
               OP_ADDI: begin
                  res  = a + sext;
                  dest = rt;
                  wr   = 1'b1;
               end
               OP_LW, OP_SW: begin
                  res = a + sext;
                  off = res - data_base;
                  if ({1'b0, off} >= DMEM_BYTES) begin
                     flt = FAULT_ADDR;
                  end else begin
                     wi = off[DMEM_AW+1:2];
                     r.mem_word = wi;
                     if (op == OP_LW) begin
                        r.mem_value = dmem[wi];
                        if (rt != '0) res = dmem[wi];
                        dest = rt;
                        wr   = 1'b1;
                     end else begin
                        dmem[wi]      = b;
                        r.mem_written = 1'b1;
                        r.mem_value   = b;
                     end
                  end
               end
               OP_BEQ, OP_BNE: begin
                  res = a - b;
                  if ((op == OP_BEQ) == (res == '0)) npc = pc4 + (sext << 2);
               end
               OP_J, OP_JAL: begin
                  npc = {pc4[31:28], ins[25:0], 2'b00};
                  if (op == OP_JAL) begin
                     res  = pc4;
                     dest = LINK_REG;
                     wr   = 1'b1;
                  end
               end
               default: flt = FAULT_OPCODE;
            endcase
            if (flt != FAULT_NONE) begin
               // faults leave every piece of state alone
               r = '0;
               r.next_pc = prog_counter;
               r.fault   = flt;
            end else begin
               prog_counter = npc;
               r.next_pc    = npc;
               r.reg_value  = res;
               if (wr && dest != '0) begin
                  gpr[dest]     = res;
                  r.reg_written = 1'b1;
                  r.reg_dest    = dest;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic string show(input rsp_item_type r);
      return $sformatf("pc=%h rw=%0d rd=%0d rv=%h mw=%0d mword=%0d mv=%h fault=%0d",
                       r.next_pc, r.reg_written, r.reg_dest, r.reg_value,
                       r.mem_written, r.mem_word, r.mem_value, r.fault);
   endfunction

   always @(posedge clock) begin
      rsp_item_type want, got;
      if (reset) begin
         prog_counter = PC_RESET;
         data_base    = DATA_BASE_RESET;
         for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
         for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
         retired_q.delete();
      end else begin
         // pop before push: a word accepted now cannot answer at this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (retired_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response word with nothing outstanding: %s", show(got));
            end else begin
               want = retired_q.pop_front();
               if (got.next_pc !== want.next_pc || got.reg_written !== want.reg_written ||
                   got.reg_dest !== want.reg_dest || got.reg_value !== want.reg_value ||
                   got.mem_written !== want.mem_written || got.mem_word !== want.mem_word ||
                   got.mem_value !== want.mem_value || got.fault !== want.fault) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected %s", show(want));
                     $display("          actual   %s", show(got));
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            retired_q.insert(retired_q.size(), retire(req_mon.payload));
         if (csr_we) data_base = csr_wdata;
      end
      pending <= retired_q.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the MIPS subset core: bursty request words, stalling response side.
module tb_top;
   import msc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_SEQS  = 170;  // random sequences per phase, one or two words each

   // codes the package does not name
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [5:0] OP_UNUSED = 6'b111111;
   localparam logic [5:0] FN_UNUSED = 6'b111111;

   typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          pending;
   int          cycle_count;
   int          burst_left;
   bit          hold_rsp;
   logic [31:0] cur_base;

   msc_req_if req_ch();
   msc_rsp_if rsp_ch();

   mips_single_cycle_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   core_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Word builders. Fields a kind does not use carry random junk, so the
   // core must really ignore them.
   // ---------------------------------------------------------------------
   function automatic logic [4:0] rand_reg();
      return 5'($urandom);
   endfunction

   function automatic req_item_type scramble();
      req_item_type w;
      w.kind          = KIND_EXEC;
      w.instruction   = $urandom;
      w.word_index    = DMEM_AW'($urandom);
      w.reg_index     = REG_AW'($urandom);
      w.preload_value = $urandom;
      return w;
   endfunction

   function automatic req_item_type exec_word(input logic [31:0] ins);
      req_item_type w;
      w = scramble();
      w.instruction = ins;
      return w;
   endfunction

   function automatic req_item_type data_word(input logic [6:0] idx, input logic [31:0] value);
      req_item_type w;
      w = scramble();
      w.kind          = KIND_DATA;
      w.word_index    = idx;
      w.preload_value = value;
      return w;
   endfunction

   function automatic req_item_type reg_word(input logic [4:0] idx, input logic [31:0] value);
      req_item_type w;
      w = scramble();
      w.kind          = KIND_REG;
      w.reg_index     = idx;
      w.preload_value = value;
      return w;
   endfunction

   function automatic req_item_type idle_word();
      req_item_type w;
      w = scramble();
      w.kind = KIND_NONE;
      return w;
   endfunction

   function automatic logic [31:0] r_ins(input logic [4:0] rs, rt, rd, sh,
                                         input logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_ins(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] j_ins(input logic [5:0] op, input logic [25:0] target);
      return {op, target};
   endfunction

   // Bias toward the values where wrap and sign bugs hide.
   function automatic logic [31:0] some_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Random add, sub, slt, sll or addi with random register fields.
   function automatic logic [31:0] alu_word();
      logic [5:0] fns [4];
      fns = '{FN_ADD, FN_SUB, FN_SLT, FN_SLL};
      if ($urandom_range(0, 4) == 0)
         return i_ins(OP_ADDI, rand_reg(), rand_reg(), 16'($urandom));
      return r_ins(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                   fns[2'($urandom_range(0, 3))]);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Present one word and hold it until the core takes it. Ready is read
   // right after the edge, before any of this edge's updates land.
   task automatic put_word(input req_item_type w);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Send a word as part of a burst; drop valid for a random gap when the
   // burst runs out. Mostly short bursts, now and then a long unbroken one.
   task automatic offer(input req_item_type w);
      put_word(w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 16);
      end
   endtask

   // Stop sending and wait for every outstanding response word. The first
   // edge is always taken so a word accepted just now is counted.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Write data_base; only called with the core idle.
   task automatic write_base(input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_base   = value;
   endtask

   // Preload a base register, then load or store through it. In range, the
   // byte address lands anywhere in the 512-byte window including the low
   // two bits; out of range, it sits just past the end, just below the base
   // or anywhere at all.
   task automatic mem_access(input logic [5:0] op, input bit in_range);
      logic [4:0]  base_reg;
      logic [4:0]  data_reg;
      logic [15:0] imm;
      logic [31:0] addr;
      base_reg = 5'($urandom_range(1, 31));
      data_reg = rand_reg();
      imm = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
      if (in_range) begin
         addr = cur_base + 32'($urandom_range(0, 511));
      end else begin
         case ($urandom_range(0, 2))
            0: addr = cur_base + 32'd512 + 32'($urandom_range(0, 15));
            1: addr = cur_base - 32'($urandom_range(1, 16));
            default: addr = $urandom;
         endcase
      end
      offer(reg_word(base_reg, addr - {{16{imm[15]}}, imm}));
      offer(exec_word(i_ins(op, base_reg, data_reg, imm)));
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall on a random pattern, drawn anew when its run ends;
   // on request, hold off for a long stretch counted here.
   // ---------------------------------------------------------------------
   initial begin
      rx_mode_type rx_mode;
      int          mode_left;
      int          beat;
      rsp_ch.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      beat      = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            beat++;
            case (rx_mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
               default:   rsp_ch.ready <= ((beat % 5) < 2);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run as a failure once the cycle limit is reached.
   // ---------------------------------------------------------------------
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d response words outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int          pick;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [31:0] phase_base;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      cur_base   = DATA_BASE_RESET;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset data_base. r1 holds the largest
      // positive value and r2 holds one.
      offer(reg_word(5'd1, 32'h7FFF_FFFF));
      offer(reg_word(5'd2, 32'd1));
      offer(reg_word(5'd0, 32'hDEAD_BEEF));                   // preload of r0 is dropped
      offer(exec_word(r_ins(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD))); // wraps to 0x80000000
      offer(exec_word(r_ins(5'd3, 5'd2, 5'd4, 5'd0, FN_SUB))); // wraps back
      offer(exec_word(r_ins(5'd3, 5'd1, 5'd5, 5'd0, FN_SLT))); // negative below positive
      offer(exec_word(r_ins(5'd0, 5'd2, 5'd6, 5'd31, FN_SLL)));
      offer(exec_word(r_ins(5'd1, 5'd2, 5'd0, 5'd0, FN_ADD))); // write to r0 dropped
      offer(exec_word(i_ins(OP_ADDI, 5'd0, 5'd7, 16'hFFFF)));  // sign-extended immediate
      offer(data_word(7'd0, 32'h8000_0000));
      offer(data_word(7'd127, 32'h7FFF_FFFF));
      offer(reg_word(5'd10, cur_base));
      offer(exec_word(i_ins(OP_LW, 5'd10, 5'd11, 16'd0)));     // first word
      offer(exec_word(i_ins(OP_LW, 5'd10, 5'd12, 16'd508)));   // last word
      offer(exec_word(i_ins(OP_SW, 5'd10, 5'd5, 16'd511)));    // low address bits ignored
      offer(exec_word(i_ins(OP_LW, 5'd10, 5'd13, 16'd512)));   // one byte past the end
      offer(exec_word(i_ins(OP_SW, 5'd10, 5'd2, 16'hFFFC)));   // below the base
      offer(exec_word(i_ins(OP_LW, 5'd10, 5'd0, 16'd4)));      // load into r0
      offer(exec_word(i_ins(OP_BEQ, 5'd1, 5'd1, 16'hFFFF)));   // taken, backward
      offer(exec_word(i_ins(OP_BNE, 5'd1, 5'd2, 16'h7FFF)));   // taken, farthest forward
      offer(exec_word(i_ins(OP_BEQ, 5'd1, 5'd2, 16'h0005)));   // not taken
      offer(exec_word(j_ins(OP_JAL, 26'h3FF_FFFF)));           // link into r31
      offer(reg_word(LINK_REG, 32'hFFFF_FFFC));
      offer(exec_word(r_ins(5'd0, 5'd0, 5'd0, 5'd0, FN_JR)));  // jump to r31
      offer(exec_word(j_ins(OP_J, 26'h0)));                    // PC + 4 wraps to zero
      offer(exec_word(j_ins(OP_UNUSED, 26'h0)));               // unknown opcode
      offer(exec_word(r_ins(5'd1, 5'd2, 5'd3, 5'd0, FN_UNUSED))); // unknown funct
      offer(idle_word());                                      // unused item kind
      drain();

      // Random phases, each under its own data_base: zero, all ones, the
      // reset value, a base whose window wraps past the top, and two random.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: phase_base = 32'h0000_0000;
            1: phase_base = 32'hFFFF_FFFF;
            3: phase_base = DATA_BASE_RESET;
            4: phase_base = 32'hFFFF_FF00;
            default: phase_base = $urandom;
         endcase
         write_base(phase_base);

         if (p == 2) begin
            // Hold the response side off while words keep coming, so the
            // core fills and stalls its input.
            hold_rsp = 1'b1;
            repeat (40) put_word(exec_word(alu_word()));
            drain();
         end

         for (int n = 0; n < PHASE_SEQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               offer(exec_word(alu_word()));
            end else if (pick < 55) begin
               // mostly well-formed accesses, a tenth aimed outside memory
               mem_access(($urandom_range(0, 1) == 1) ? OP_LW : OP_SW,
                          $urandom_range(0, 9) != 0);
            end else if (pick < 65) begin
               rs = rand_reg();
               rt = ($urandom_range(0, 2) == 0) ? rs : rand_reg();
               offer(exec_word(i_ins(($urandom_range(0, 1) == 1) ? OP_BEQ : OP_BNE,
                                     rs, rt, 16'($urandom))));
            end else if (pick < 72) begin
               offer(exec_word(j_ins(($urandom_range(0, 1) == 1) ? OP_J : OP_JAL,
                                     26'($urandom))));
            end else if (pick < 78) begin
               if ($urandom_range(0, 1) == 1) offer(reg_word(LINK_REG, some_value()));
               offer(exec_word(r_ins(rand_reg(), rand_reg(), rand_reg(), rand_reg(), FN_JR)));
            end else if (pick < 86) begin
               offer(reg_word(rand_reg(), some_value()));
            end else if (pick < 93) begin
               offer(data_word(7'($urandom), some_value()));
            end else begin
               // noise: raw instruction bits, odd funct codes, unused kind
               case ($urandom_range(0, 2))
                  0: offer(exec_word($urandom));
                  1: offer(exec_word(r_ins(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                                           6'($urandom))));
                  default: offer(idle_word());
               endcase
            end
         end
         drain();
      end

      // Let any stray late response word show up before the verdict.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
